/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ils_pkg.sv */
package ils_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 10;
  localparam int ACT_W        = 3;
  localparam int ST_W         = 2;
  localparam int LEN_W        = 5;

  localparam logic [ACT_W-1:0] ACT_GET  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HEAD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TAIL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_AT   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL  = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos;
  } ils_ctl_t;

endpackage

/* rtl/ils_cell.sv */
module ils_cell
  import ils_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  ils_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value_q
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  // On an insert, the slot takes the new value and cells above it take their lower
  // neighbor; on a delete, the slot and every cell above it take their upper neighbor.
  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (MY_POS > ctl.pos) begin
        value_nxt = left_value;
      end else if (MY_POS == ctl.pos) begin
        value_nxt = new_value;
      end
    end else if (ctl.del) begin
      if (MY_POS >= ctl.pos) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_q = value_r;

endmodule

/* rtl/indexed_list_store_unit.sv */
// Channel  | Ports                                      | Handshake
// ---------+--------------------------------------------+----------------------------
// request  | in_action, in_position, in_value           | start high, busy low
// result   | out_read_value, out_status, out_length     | out_valid for one cycle
//
// One request is taken every cycle; busy never rises.
// The result appears in the cycle after the request transfer, held by the single
// register stage behind the row of cells, which all shift in the same cycle.
// Reset empties the list (length zero); the entry registers are not cleared.
// The receiver cannot stall, so no result is ever held back.
module indexed_list_store_unit
  import ils_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACT_W-1:0]         in_action,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [ST_W-1:0]          out_status,
  output logic [LEN_W-1:0]         out_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  logic                     accept;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic [POS_W-1:0]         count_pos;
  logic                     valid_r;
  logic signed [DATA_W-1:0] rd_r;
  logic signed [DATA_W-1:0] rd_nxt;
  logic [ST_W-1:0]          st_r;
  logic [ST_W-1:0]          st_nxt;
  logic                     do_ins;
  logic                     do_del;
  logic [POS_W-1:0]         ins_at;
  ils_ctl_t                 ctl;
  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  logic [CW+LEN_W-1:0]      count_ext;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign count_pos = {{(POS_W-CW){1'b0}}, count_r};

  always_comb begin
    rd_nxt = '0;
    st_nxt = ST_DONE;
    do_ins = 1'b0;
    do_del = 1'b0;
    ins_at = '0;
    case (in_action)
      ACT_GET: begin
        if (in_position < count_pos) begin
          rd_nxt = cell_q[in_position[IW-1:0]];
        end else begin
          rd_nxt = -32'sd1;
          st_nxt = ST_IGNORED;
        end
      end
      ACT_HEAD: begin
        do_ins = 1'b1;
      end
      ACT_TAIL: begin
        do_ins = 1'b1;
        ins_at = count_pos;
      end
      ACT_AT: begin
        if (in_position > count_pos) begin
          st_nxt = ST_IGNORED;
        end else begin
          do_ins = 1'b1;
          ins_at = in_position;
        end
      end
      ACT_DEL: begin
        if (in_position < count_pos) begin
          do_del = 1'b1;
        end else begin
          st_nxt = ST_IGNORED;
        end
      end
      default: begin
        st_nxt = ST_IGNORED;
      end
    endcase
    // A full list refuses an otherwise valid insert and stays unchanged.
    if (do_ins && (count_pos >= CAP_POS)) begin
      do_ins = 1'b0;
      st_nxt = ST_FULL;
    end
  end

  always_comb begin
    ctl.ins   = accept && do_ins;
    ctl.del   = accept && do_del;
    ctl.pos   = do_del ? in_position : ins_at;
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;
    if (i == 0) begin : g_first
      assign left_value = in_value;
    end else begin : g_inner_left
      assign left_value = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner_right
      assign right_value = cell_q[i+1];
    end
    ils_cell #(
      .IDX(i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_value   (in_value),
      .left_value  (left_value),
      .right_value (right_value),
      .value_q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= rd_nxt;
      st_r <= st_nxt;
    end
  end

  assign count_ext      = {{LEN_W{1'b0}}, count_r};
  assign out_valid      = valid_r;
  assign out_read_value = rd_r;
  assign out_status     = st_r;
  assign out_length     = count_ext[LEN_W-1:0];

endmodule

/* rtl/ils_checker.sv */
`include "assert_macros.svh"

module ils_checker
  import ils_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [ACT_W-1:0]         in_action,
  input logic                     out_valid,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic [ST_W-1:0]          out_status
);

  // Every transfer in yields exactly one result in the following cycle.
  `ASSERT_NEXT(a_result_follows, start && !busy, out_valid)
  `ASSERT_SAME(a_no_spurious_result, out_valid, $past(start && !busy))
  // A missed get reads back minus one.
  `ASSERT_SAME(a_get_miss_value,
    out_valid && (out_status == ST_IGNORED) && ($past(in_action) == ACT_GET),
    out_read_value == -32'sd1)
  // Only a get carries a read value.
  `ASSERT_SAME(a_non_get_zero, out_valid && ($past(in_action) != ACT_GET),
    out_read_value == 32'sd0)

endmodule

bind indexed_list_store_unit ils_checker u_ils_checker (.*);

/* test/tb_indexed_list_store_unit.sv */
`timescale 1ns / 100ps

module tb_indexed_list_store_unit;
  import ils_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam logic [ACT_W-1:0] ACT_MAX = {ACT_W{1'b1}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_TOP = {POS_W{1'b1}};
  localparam int RANDOM_ITEMS = 1550;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  // Mirrors the list contents and holds the results still owed by the block.
  class list_scoreboard;
    logic signed [DATA_W-1:0] cells [LIST_CAP];
    int count;
    list_result_t owed [$];
    int errors;
    int n_requests;
    int n_hits;
    int n_ignored;
    int n_full;
    int max_len;

    function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_result_t res;
      int ins_at;
      bit do_ins;
      int i;
      res = '0;
      res.status = ST_DONE;
      ins_at = 0;
      do_ins = 1'b0;
      case (act)
        ACT_GET: begin
          if (pos < count) begin
            res.read_value = cells[pos];
            n_hits++;
          end else begin
            res.read_value = -1;
            res.status = ST_IGNORED;
          end
        end
        ACT_HEAD: begin
          ins_at = 0;
          do_ins = 1'b1;
        end
        ACT_TAIL: begin
          ins_at = count;
          do_ins = 1'b1;
        end
        ACT_AT: begin
          // A position past the end wins over the full check.
          if (pos > count) begin
            res.status = ST_IGNORED;
          end else begin
            ins_at = pos;
            do_ins = 1'b1;
          end
        end
        ACT_DEL: begin
          if (pos < count) begin
            for (i = pos; i + 1 < count; i++) cells[i] = cells[i + 1];
            count--;
          end else begin
            res.status = ST_IGNORED;
          end
        end
        default: res.status = ST_IGNORED;
      endcase
      if (do_ins) begin
        if (count >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          for (i = count; i > ins_at; i--) cells[i] = cells[i - 1];
          cells[ins_at] = val;
          count++;
        end
      end
      res.length = LEN_W'(count);
      if (res.status == ST_IGNORED) n_ignored++;
      if (res.status == ST_FULL) n_full++;
      if (count > max_len) max_len = count;
      n_requests++;
      owed.push_back(res);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] rd, logic [ST_W-1:0] st,
                               logic [LEN_W-1:0] len);
      list_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing expected: read_value %0d status %0d length %0d",
                 $time, rd, st, len);
        errors++;
      end else begin
        want = owed.pop_front();
        if (rd !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %0d, actual %0d",
                   $time, want.read_value, rd);
          errors++;
        end
        if (st !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, st);
          errors++;
        end
        if (len !== want.length) begin
          $display("%0t: length mismatch: expected %0d, actual %0d", $time, want.length, len);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [ACT_W-1:0]         in_action;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_read_value;
  logic [ST_W-1:0]          out_status;
  logic [LEN_W-1:0]         out_length;

  list_scoreboard sb = new();
  bit idle_on;

  indexed_list_store_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_read_value, out_status, out_length);
    end
  end

  // Idle cycles carry random fields so that ignored inputs get exercised too.
  task automatic send_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
    while (idle_on && $urandom_range(0, 99) < 29) begin
      @(negedge clk);
      start <= 1'b0;
      in_action <= ACT_W'($urandom);
      in_position <= POS_W'($urandom);
      in_value <= $urandom;
    end
    @(negedge clk);
    start <= 1'b1;
    in_action <= act;
    in_position <= pos;
    in_value <= val;
    do @(posedge clk); while (busy);
    sb.note_request(act, pos, val);
  endtask

  task automatic random_request(int grow_pct);
    int r;
    int n;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] val;
    n = sb.count;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      act = ACT_W'(ACT_DEL + $urandom_range(1, ACT_MAX - ACT_DEL));
    end else if (r < 25) begin
      act = ACT_GET;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0: act = ACT_HEAD;
        1: act = ACT_TAIL;
        default: act = ACT_AT;
      endcase
    end else begin
      act = ACT_DEL;
    end
    r = $urandom_range(0, 99);
    if (r < 8) pos = POS_W'($urandom);
    else if (r < 18) pos = POS_W'(n + $urandom_range(0, 2));
    else if (act == ACT_AT) pos = POS_W'($urandom_range(0, n));
    else if (n > 0) pos = POS_W'($urandom_range(0, n - 1));
    else pos = '0;
    case ($urandom_range(0, 39))
      0: val = VAL_MIN;
      1: val = VAL_MAX;
      2: val = -1;
      3: val = '0;
      default: val = $urandom;
    endcase
    send_request(act, pos, val);
  endtask

  initial begin
    int c;
    int k;
    int grow [4];
    grow = '{85, 50, 15, 50};
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_GET;
    in_position = '0;
    in_value = '0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: reads, deletes, a far add miss; then adds, reads, bad ops.
    send_request(ACT_GET, '0, '0);
    send_request(ACT_DEL, '0, '0);
    send_request(ACT_AT, POS_W'(1), 5);
    send_request(ACT_AT, '0, VAL_MIN);
    send_request(ACT_HEAD, POS_TOP, VAL_MAX);
    send_request(ACT_TAIL, '0, -1);
    send_request(ACT_AT, POS_W'(1), '0);
    send_request(ACT_GET, POS_W'(3), '0);
    send_request(ACT_GET, POS_W'(4), '0);
    send_request(ACT_GET, POS_TOP, '0);
    for (c = ACT_DEL + 1; c <= ACT_MAX; c++) begin
      send_request(ACT_W'(c), POS_W'(0), '1);
    end
    // Fill up, alternating tail appends with inserts in the middle.
    while (sb.count < LIST_CAP) begin
      if (sb.count % 2 == 1) send_request(ACT_TAIL, '0, $urandom);
      else send_request(ACT_AT, POS_W'(sb.count / 2), $urandom);
    end
    send_request(ACT_HEAD, '0, 7);
    send_request(ACT_TAIL, '0, 8);
    send_request(ACT_AT, POS_W'(LIST_CAP), 9);
    send_request(ACT_AT, POS_W'(LIST_CAP + 1), 10);
    send_request(ACT_GET, POS_W'(LIST_CAP - 1), '0);
    send_request(ACT_DEL, POS_W'(LIST_CAP - 1), '0);
    send_request(ACT_DEL, '0, '0);
    send_request(ACT_DEL, POS_TOP, '0);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      idle_on = !(k >= 600 && k < 900);
      random_request(grow[(k / 100) % 4]);
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d list requests: %0d reads that hit, %0d ignored, %0d adds refused as full.",
             sb.n_requests, sb.n_hits, sb.n_ignored, sb.n_full);
    $display("The list held up to %0d entries during the run.", sb.max_len);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out waiting for the list store.");
    $display("Verification failed");
    $finish;
  end

endmodule
